[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file wlsb_chk.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define WLSB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define WLSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/wlsb_pkg.sv]
// Shared types, codes and helpers of the W-LSB bit-count encoder.
// No dependencies; used by the top level, front, queue and back end.
package wlsb_pkg;

  localparam int DATA_W  = 32;
  localparam int BITS_W  = 6;
  localparam int LIMIT_W = 3;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_SHIFT = 2'd2;

  // field width modes; the unused code acts as 32 bits
  localparam logic [MODE_W-1:0] MODE_8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_32 = 2'd2;

  typedef struct packed {
    logic              is_query;
    logic [DATA_W-1:0] word;      // add: raw value; query: value + shift
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0]  width_mode;
    logic [LIMIT_W-1:0] window_limit;
    logic [DATA_W-1:0]  interval_shift;
  } cfg_t;

  function automatic logic [BITS_W-1:0] field_bits(input logic [MODE_W-1:0] mode);
    logic [BITS_W-1:0] w;
    if (mode == MODE_8) begin
      w = 6'd8;
    end else if (mode == MODE_16) begin
      w = 6'd16;
    end else begin
      w = 6'd32;
    end
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] field_mask(input logic [MODE_W-1:0] mode);
    logic [DATA_W-1:0] m;
    if (mode == MODE_8) begin
      m = 32'h0000_00FF;
    end else if (mode == MODE_16) begin
      m = 32'h0000_FFFF;
    end else begin
      m = 32'hFFFF_FFFF;
    end
    return m;
  endfunction

endpackage

[hw/rtl/wlsb_if.sv]
// Handshake channel interfaces of the W-LSB encoder: request and response.
// Depends on nothing; carries valid, ready and the word fields.
interface wlsb_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] value;
  modport source (output valid, req_type, value, input ready);
  modport sink   (input valid, req_type, value, output ready);
endinterface

interface wlsb_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] bits_needed;
  modport source (output valid, bits_needed, input ready);
  modport sink   (input valid, bits_needed, output ready);
endinterface

[hw/rtl/wlsb_min_bits_encoder.sv]
// Top level of the W-LSB bit-count encoder: config registers, front, queue, back.
// Depends on wlsb_pkg, wlsb_if, wlsb_front, wlsb_fifo and wlsb_back.
//
// Usage:
//   req  - request words: req_type 0 adds value to the reference window,
//          req_type 1 asks for the bits needed to send value. One word per
//          valid/ready handshake.
//   rsp  - one bits_needed word per query; adds give no response.
//   cfg  - write port (cfg_we, cfg_index, cfg_data): 0 field width mode,
//          1 window limit, 2 interval shift p. Write only while idle.
// Processing:
//   An add is taken from the queue and stored in the next window slot. A
//   query leaves the queue, folds the per-slot offsets of the used slots
//   (one subtract per cycle), runs a top-down bit scan, then holds the
//   response until it is taken. A query on an empty window answers with
//   the field width and skips the fold and the scan.
// Stalls: the two-word queue keeps taking requests while the back end works;
//   req.ready drops whenever it is full, behind a long query or a stalled response.
// Reset: synchronous, clears the window (no used slots, count zero) and
//   loads width mode 32-bit, window limit 4, shift 0.
module wlsb_min_bits_encoder #(
  parameter int WINDOW_SLOTS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  wlsb_req_if.sink                            req,
  wlsb_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [wlsb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wlsb_pkg::DATA_W-1:0]         cfg_data
);

  wlsb_pkg::cfg_t cfg;
  wlsb_pkg::cmd_t push_cmd;
  wlsb_pkg::cmd_t head_cmd;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_empty;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_mode     <= wlsb_pkg::MODE_32;
      cfg.window_limit   <= 3'd4;
      cfg.interval_shift <= '0;
    end else if (cfg_we) begin
      if (cfg_index == wlsb_pkg::REG_WIDTH_MODE) begin
        cfg.width_mode <= cfg_data[wlsb_pkg::MODE_W-1:0];
      end
      if (cfg_index == wlsb_pkg::REG_WINDOW_LIMIT) begin
        cfg.window_limit <= cfg_data[wlsb_pkg::LIMIT_W-1:0];
      end
      if (cfg_index == wlsb_pkg::REG_INTERVAL_SHIFT) begin
        cfg.interval_shift <= cfg_data;
      end
    end
  end

  wlsb_front u_front (
    .req            (req),
    .interval_shift (cfg.interval_shift),
    .queue_full     (queue_full),
    .push           (push),
    .cmd            (push_cmd)
  );

  wlsb_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_cmd),
    .pop   (pop),
    .dout  (head_cmd),
    .full  (queue_full),
    .empty (queue_empty)
  );

  wlsb_back #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_empty (queue_empty),
    .cmd         (head_cmd),
    .pop         (pop),
    .rsp         (rsp)
  );

endmodule

[hw/rtl/wlsb_front.sv]
// Front end: accepts request words, classifies them and builds queue commands.
// Depends on wlsb_pkg and wlsb_if.
module wlsb_front (
  wlsb_req_if.sink                      req,
  input  logic [wlsb_pkg::DATA_W-1:0]   interval_shift,
  input  logic                          queue_full,
  output logic                          push,
  output wlsb_pkg::cmd_t                cmd
);

  assign req.ready = !queue_full;
  assign push      = req.valid && !queue_full;

  // a query only ever needs value + p, so fold the offset in here
  always_comb begin
    cmd.is_query = (req.req_type == wlsb_pkg::REQ_QUERY);
    cmd.word     = cmd.is_query ? (req.value + interval_shift) : req.value;
  end

endmodule

[hw/rtl/wlsb_fifo.sv]
// Two-entry command queue between the front and back ends.
// Depends on wlsb_pkg.
module wlsb_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wlsb_pkg::cmd_t din,
  input  logic           pop,
  output wlsb_pkg::cmd_t dout,
  output logic           full,
  output logic           empty
);

  wlsb_pkg::cmd_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

[hw/rtl/wlsb_back.sv]
// Back end: holds the reference window, applies adds and runs bit-count queries.
// Depends on wlsb_pkg and wlsb_if.
module wlsb_back #(
  parameter int WINDOW_SLOTS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  wlsb_pkg::cfg_t cfg,
  input  logic           queue_empty,
  input  wlsb_pkg::cmd_t cmd,
  output logic           pop,
  wlsb_rsp_if.source     rsp
);

  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SLOT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                     state;
  logic [SLOT_W-1:0]              slot_idx;
  logic [SLOT_W-1:0]              next_slot;
  logic [WINDOW_SLOTS-1:0]        slot_used;
  logic [wlsb_pkg::LIMIT_W-1:0]   value_count;
  logic [wlsb_pkg::BITS_W-1:0]    cnt;
  logic [wlsb_pkg::DATA_W-1:0]    ref_values [WINDOW_SLOTS];
  logic [wlsb_pkg::DATA_W-1:0]    vp;
  logic [wlsb_pkg::DATA_W-1:0]    acc;
  logic [wlsb_pkg::DATA_W-1:0]    off;
  logic [wlsb_pkg::DATA_W-1:0]    mask;
  logic [wlsb_pkg::BITS_W-1:0]    width;
  logic [wlsb_pkg::BITS_W-1:0]    cnt_m1;
  logic                           take_add;
  logic                           take_query;

  assign mask       = wlsb_pkg::field_mask(cfg.width_mode);
  assign width      = wlsb_pkg::field_bits(cfg.width_mode);
  assign pop        = (state == ST_IDLE) && !queue_empty;
  assign take_add   = pop && !cmd.is_query;
  assign take_query = pop && cmd.is_query;
  assign off        = (vp - ref_values[slot_idx]) & mask;
  assign cnt_m1     = cnt - 6'd1;

  assign rsp.valid       = (state == ST_OUT);
  assign rsp.bits_needed = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot_idx    <= '0;
      next_slot   <= '0;
      slot_used   <= '0;
      value_count <= '0;
      cnt         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take_add) begin
            // at the limit the count holds; otherwise it counts (3-bit wrap)
            if (value_count != cfg.window_limit) value_count <= value_count + 3'd1;
            slot_used[next_slot] <= 1'b1;
            next_slot <= (next_slot == LAST_SLOT) ? '0 : next_slot + SLOT_ONE;
          end else if (take_query) begin
            slot_idx <= '0;
            if (value_count == '0) begin
              cnt   <= width;
              state <= ST_OUT;
            end else begin
              state <= ST_SLOT;
            end
          end
        end
        ST_SLOT: begin
          if (slot_idx == LAST_SLOT) begin
            cnt   <= width;
            state <= ST_SCAN;
          end else begin
            slot_idx <= slot_idx + SLOT_ONE;
          end
        end
        ST_SCAN: begin
          // walk down from the top bit; stop at the highest set offset bit
          if (cnt == '0 || acc[cnt_m1[4:0]]) begin
            state <= ST_OUT;
          end else begin
            cnt <= cnt_m1;
          end
        end
        ST_OUT: begin
          if (rsp.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: OR of all used offsets; its bit length is the answer
  always_ff @(posedge clk) begin
    if (take_query) begin
      vp  <= cmd.word;
      acc <= '0;
    end else if (state == ST_SLOT && slot_used[slot_idx]) begin
      acc <= acc | off;
    end
  end

  always_ff @(posedge clk) begin
    if (take_add) ref_values[next_slot] <= cmd.word;
  end

endmodule

[hw/rtl/wlsb_chk.sv]
// Port-level checks on the response channel of the W-LSB encoder, plus bind.
// Depends on assert_macros.svh and wlsb_min_bits_encoder.
`include "assert_macros.svh"

module wlsb_chk (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [5:0] bits_needed
);

  `WLSB_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped while stalled")
  `WLSB_ASSERT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready |=> $stable(bits_needed), "rsp word changed while stalled")
  `WLSB_ASSERT(a_bits_range, clk, rst, rsp_valid |-> bits_needed <= 6'd32, "bits_needed above 32")
  `WLSB_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind wlsb_min_bits_encoder wlsb_chk u_wlsb_chk (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .bits_needed (rsp.bits_needed)
);
